@@ hw/rtl/plt_pkg.sv @@
// Property-list tokenizer package: token kinds, lexer modes, byte codes,
// and the result item struct. No dependencies.
package plt_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_PLAIN   = 2'd1,
    MODE_QUOTED  = 2'd2,
    MODE_ESCAPED = 2'd3
  } mode_t;

  typedef logic [3:0] kind_t;

  localparam kind_t KIND_CHAR   = 4'd0;
  localparam kind_t KIND_END    = 4'd1;
  localparam kind_t KIND_COMMA  = 4'd2;
  localparam kind_t KIND_COLON  = 4'd3;
  localparam kind_t KIND_SEMI   = 4'd4;
  localparam kind_t KIND_LPAREN = 4'd5;
  localparam kind_t KIND_RPAREN = 4'd6;
  localparam kind_t KIND_LBRACE = 4'd7;
  localparam kind_t KIND_RBRACE = 4'd8;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    kind_t      token_kind;
    logic [7:0] char_value;
    logic       was_quoted;
    logic       run_last;
  } result_t;

  function automatic result_t make_result(kind_t kind, logic [7:0] chr, logic quoted);
    result_t r;
    r.token_kind = kind;
    r.char_value = (kind == KIND_CHAR) ? chr : 8'd0;
    r.was_quoted = quoted;
    r.run_last   = 1'b0;
    return r;
  endfunction

  function automatic kind_t punct_kind(logic [7:0] b);
    kind_t k;
    unique case (b)
      CH_COMMA:  k = KIND_COMMA;
      CH_COLON:  k = KIND_COLON;
      CH_SEMI:   k = KIND_SEMI;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      default:   k = KIND_CHAR;
    endcase
    return k;
  endfunction

endpackage

@@ hw/rtl/plt_if.sv @@
// Valid/ready channel interfaces for the tokenizer's byte input and token output.
// Depends on nothing.
interface plt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, text_byte, final_byte, input ready);
  modport sink   (input valid, text_byte, final_byte, output ready);
endinterface

interface plt_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;
  logic [7:0] char_value;
  logic       was_quoted;
  logic       run_last;

  modport source (output valid, token_kind, char_value, was_quoted, run_last, input ready);
  modport sink   (input valid, token_kind, char_value, was_quoted, run_last, output ready);
endinterface

@@ hw/rtl/plt_lex.sv @@
// Tokenizer step: lexer mode state and the per-byte decode into up to two
// result items. Depends on plt_pkg.
module plt_lex (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       text_byte,
  input  logic             final_byte,
  output plt_pkg::result_t res0,
  output plt_pkg::result_t res1,
  output logic [1:0]       res_cnt,
  output plt_pkg::mode_t   mode
);

  plt_pkg::mode_t mode_r, mode_nxt;
  logic           single_r, single_nxt;

  logic             blank, quote, is_punct;
  plt_pkg::kind_t   pk;
  logic [7:0]       close_q;
  logic             idle_emit;
  plt_pkg::result_t idle_res;
  plt_pkg::mode_t   idle_mode;

  assign mode = mode_r;

  always_comb begin
    blank    = (text_byte == plt_pkg::CH_SPACE) || (text_byte == plt_pkg::CH_TAB) ||
               (text_byte == plt_pkg::CH_CR) || (text_byte == plt_pkg::CH_LF);
    quote    = (text_byte == plt_pkg::CH_DQUOTE) || (text_byte == plt_pkg::CH_SQUOTE);
    pk       = plt_pkg::punct_kind(text_byte);
    is_punct = (pk != plt_pkg::KIND_CHAR);
    close_q  = single_r ? plt_pkg::CH_SQUOTE : plt_pkg::CH_DQUOTE;
  end

  // handling of a byte when no string is open
  always_comb begin
    idle_emit = 1'b0;
    idle_res  = plt_pkg::make_result(plt_pkg::KIND_CHAR, text_byte, 1'b0);
    idle_mode = plt_pkg::MODE_IDLE;
    priority if (blank) begin
      idle_emit = 1'b0;
    end else if (is_punct) begin
      idle_emit = 1'b1;
      idle_res  = plt_pkg::make_result(pk, 8'd0, 1'b0);
    end else if (quote) begin
      idle_mode = plt_pkg::MODE_QUOTED;
    end else begin
      idle_emit = 1'b1;
      idle_mode = plt_pkg::MODE_PLAIN;
    end
  end

  always_comb begin
    res0       = plt_pkg::make_result(plt_pkg::KIND_CHAR, 8'd0, 1'b0);
    res1       = res0;
    res_cnt    = 2'd0;
    mode_nxt   = mode_r;
    single_nxt = single_r;

    unique case (mode_r)
      plt_pkg::MODE_IDLE: begin
        if (idle_emit) begin
          res0    = idle_res;
          res_cnt = 2'd1;
        end
        mode_nxt = idle_mode;
        if (quote) single_nxt = (text_byte == plt_pkg::CH_SQUOTE);
      end
      plt_pkg::MODE_PLAIN: begin
        if (blank || is_punct || quote) begin
          res0    = plt_pkg::make_result(plt_pkg::KIND_END, 8'd0, 1'b0);
          res_cnt = 2'd1;
          if (idle_emit) begin
            res1    = idle_res;
            res_cnt = 2'd2;
          end
          mode_nxt = idle_mode;
          if (quote) single_nxt = (text_byte == plt_pkg::CH_SQUOTE);
        end else begin
          res0    = plt_pkg::make_result(plt_pkg::KIND_CHAR, text_byte, 1'b0);
          res_cnt = 2'd1;
        end
      end
      plt_pkg::MODE_QUOTED: begin
        if (text_byte == close_q) begin
          res0       = plt_pkg::make_result(plt_pkg::KIND_END, 8'd0, 1'b1);
          res_cnt    = 2'd1;
          mode_nxt   = plt_pkg::MODE_IDLE;
          single_nxt = 1'b0;
        end else if (text_byte == plt_pkg::CH_BSLASH) begin
          mode_nxt = plt_pkg::MODE_ESCAPED;
        end else begin
          res0    = plt_pkg::make_result(plt_pkg::KIND_CHAR, text_byte, 1'b1);
          res_cnt = 2'd1;
        end
      end
      plt_pkg::MODE_ESCAPED: begin
        res0     = plt_pkg::make_result(plt_pkg::KIND_CHAR, text_byte, 1'b1);
        res_cnt  = 2'd1;
        mode_nxt = plt_pkg::MODE_QUOTED;
      end
      default: mode_nxt = plt_pkg::MODE_IDLE;
    endcase

    // last byte closes any open string
    if (final_byte) begin
      if (mode_nxt != plt_pkg::MODE_IDLE) begin
        if (res_cnt == 2'd0) begin
          res0 = plt_pkg::make_result(plt_pkg::KIND_END, 8'd0,
                                      mode_nxt != plt_pkg::MODE_PLAIN);
        end else begin
          res1 = plt_pkg::make_result(plt_pkg::KIND_END, 8'd0,
                                      mode_nxt != plt_pkg::MODE_PLAIN);
        end
        res_cnt = res_cnt + 2'd1;
      end
      mode_nxt   = plt_pkg::MODE_IDLE;
      single_nxt = 1'b0;
    end

    if (res_cnt == 2'd1) res0.run_last = 1'b1;
    if (res_cnt == 2'd2) res1.run_last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= plt_pkg::MODE_IDLE;
      single_r <= 1'b0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      single_r <= single_nxt;
    end
  end

endmodule

@@ hw/rtl/property_list_tokenizer_core.sv @@
// Property-list tokenizer top level: input byte register, lexer step, and a
// four-entry result queue. Depends on plt_pkg, plt_if and plt_lex.
// Each byte is registered, then its results are written into the result queue.
// Throughput: one byte per cycle while two queue entries are free; a byte yields
// 0 to 2 results; the output drains one per cycle and so paces two-result bytes.
// Reset (synchronous, active low) returns the lexer to idle and empties the queue.
module property_list_tokenizer_core (
  input logic        clk,
  input logic        rst_n,
  plt_in_if.sink     in_ch,
  plt_out_if.source  out_ch
);

  localparam int QDEPTH = 4;

  logic             stage_v_r;
  logic [7:0]       stage_byte_r;
  logic             stage_fin_r;
  logic             stage_go;

  plt_pkg::result_t res0, res1;
  logic [1:0]       res_cnt;
  plt_pkg::mode_t   lex_mode;

  plt_pkg::result_t q_r [QDEPTH];
  logic [1:0]       wr_ptr_r, rd_ptr_r;
  logic [2:0]       cnt_r, cnt_nxt;
  logic             pop;
  logic [2:0]       push_n;

  assign stage_go    = stage_v_r && (cnt_r <= 3'd2);
  assign in_ch.ready = !stage_v_r || stage_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      stage_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      stage_byte_r <= in_ch.text_byte;
      stage_fin_r  <= in_ch.final_byte;
    end
  end

  plt_lex u_lex (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (stage_go),
    .text_byte  (stage_byte_r),
    .final_byte (stage_fin_r),
    .res0       (res0),
    .res1       (res1),
    .res_cnt    (res_cnt),
    .mode       (lex_mode)
  );

  assign pop     = out_ch.valid && out_ch.ready;
  assign push_n  = stage_go ? {1'b0, res_cnt} : 3'd0;
  assign cnt_nxt = cnt_r + push_n - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_n[1:0];
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 3'd0) q_r[wr_ptr_r] <= res0;
    if (push_n == 3'd2) q_r[wr_ptr_r + 2'd1] <= res1;
  end

  assign out_ch.valid      = (cnt_r != 3'd0);
  assign out_ch.token_kind = q_r[rd_ptr_r].token_kind;
  assign out_ch.char_value = q_r[rd_ptr_r].char_value;
  assign out_ch.was_quoted = q_r[rd_ptr_r].was_quoted;
  assign out_ch.run_last   = q_r[rd_ptr_r].run_last;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(QDEPTH))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stage_go |-> (cnt_r + push_n) <= 3'(QDEPTH))
    else $error("result queue overflow on push");

  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_go && stage_fin_r) |=> lex_mode == plt_pkg::MODE_IDLE)
    else $error("lexer not idle after last byte");

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for property_list_tokenizer_core: byte stream in, tokens out,
// each token compared against an in-bench tokenizer model. Needs plt_pkg and plt_if.
`timescale 1ns / 100ps

module tb_top;

  localparam int STALL_LIMIT = 2000;
  localparam int TARGET_BYTES = 1500;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } byte_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  plt_in_if  in_bus ();
  plt_out_if out_bus ();

  property_list_tokenizer_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_item_t        pending_bytes[$];
  plt_pkg::result_t  expected_tokens[$];
  plt_pkg::result_t  byte_tokens[$];
  int                total_items = 0;
  int                bytes_taken = 0;
  int                error_count = 0;
  int                send_gap = 0;
  int                recv_gap = 0;
  int                hold_left = 0;
  bit                hold_done = 1'b0;
  int                idle_cycles = 0;
  byte_item_t        next_item;
  plt_pkg::result_t  seen;
  plt_pkg::result_t  want;

  // tokenizer state tracked alongside the DUT
  plt_pkg::mode_t    lex_state = plt_pkg::MODE_IDLE;
  logic              quote_single = 1'b0;

  function automatic plt_pkg::kind_t punct_token(logic [7:0] b);
    case (b)
      plt_pkg::CH_COMMA:  return plt_pkg::KIND_COMMA;
      plt_pkg::CH_COLON:  return plt_pkg::KIND_COLON;
      plt_pkg::CH_SEMI:   return plt_pkg::KIND_SEMI;
      plt_pkg::CH_LPAREN: return plt_pkg::KIND_LPAREN;
      plt_pkg::CH_RPAREN: return plt_pkg::KIND_RPAREN;
      plt_pkg::CH_LBRACE: return plt_pkg::KIND_LBRACE;
      plt_pkg::CH_RBRACE: return plt_pkg::KIND_RBRACE;
      default:            return plt_pkg::KIND_CHAR;
    endcase
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return (b == plt_pkg::CH_SPACE) || (b == plt_pkg::CH_TAB) ||
           (b == plt_pkg::CH_CR) || (b == plt_pkg::CH_LF);
  endfunction

  function automatic bit is_quote(logic [7:0] b);
    return (b == plt_pkg::CH_DQUOTE) || (b == plt_pkg::CH_SQUOTE);
  endfunction

  function automatic bit ends_word(logic [7:0] b);
    return is_blank(b) || is_quote(b) || (punct_token(b) != plt_pkg::KIND_CHAR);
  endfunction

  task automatic push_token(plt_pkg::kind_t kind, logic [7:0] chr, logic quoted);
    plt_pkg::result_t r;
    r.token_kind = kind;
    r.char_value = (kind == plt_pkg::KIND_CHAR) ? chr : 8'd0;
    r.was_quoted = quoted;
    r.run_last   = 1'b0;
    byte_tokens.push_back(r);
  endtask

  task automatic start_token(logic [7:0] b);
    if (!is_blank(b)) begin
      if (punct_token(b) != plt_pkg::KIND_CHAR) begin
        push_token(punct_token(b), 8'd0, 1'b0);
      end else if (is_quote(b)) begin
        lex_state    = plt_pkg::MODE_QUOTED;
        quote_single = (b == plt_pkg::CH_SQUOTE);
      end else begin
        push_token(plt_pkg::KIND_CHAR, b, 1'b0);
        lex_state = plt_pkg::MODE_PLAIN;
      end
    end
  endtask

  task automatic predict_tokens(logic [7:0] b, logic fin);
    logic [7:0] close_q;
    close_q = quote_single ? plt_pkg::CH_SQUOTE : plt_pkg::CH_DQUOTE;
    byte_tokens.delete();
    case (lex_state)
      plt_pkg::MODE_IDLE: start_token(b);
      plt_pkg::MODE_PLAIN: begin
        if (ends_word(b)) begin
          push_token(plt_pkg::KIND_END, 8'd0, 1'b0);
          lex_state = plt_pkg::MODE_IDLE;
          start_token(b);
        end else begin
          push_token(plt_pkg::KIND_CHAR, b, 1'b0);
        end
      end
      plt_pkg::MODE_QUOTED: begin
        if (b == close_q) begin
          push_token(plt_pkg::KIND_END, 8'd0, 1'b1);
          lex_state    = plt_pkg::MODE_IDLE;
          quote_single = 1'b0;
        end else if (b == plt_pkg::CH_BSLASH) begin
          lex_state = plt_pkg::MODE_ESCAPED;
        end else begin
          push_token(plt_pkg::KIND_CHAR, b, 1'b1);
        end
      end
      default: begin
        push_token(plt_pkg::KIND_CHAR, b, 1'b1);
        lex_state = plt_pkg::MODE_QUOTED;
      end
    endcase
    if (fin) begin
      if (lex_state == plt_pkg::MODE_PLAIN) begin
        push_token(plt_pkg::KIND_END, 8'd0, 1'b0);
      end else if (lex_state != plt_pkg::MODE_IDLE) begin
        push_token(plt_pkg::KIND_END, 8'd0, 1'b1);
      end
      lex_state    = plt_pkg::MODE_IDLE;
      quote_single = 1'b0;
    end
    if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].run_last = 1'b1;
    foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
  endtask

  // stimulus helpers
  task automatic add_byte(logic [7:0] b, logic fin);
    byte_item_t it;
    it.text_byte  = b;
    it.final_byte = fin;
    pending_bytes.push_back(it);
  endtask

  task automatic close_text();
    byte_item_t it;
    it = pending_bytes.pop_back();
    it.final_byte = 1'b1;
    pending_bytes.push_back(it);
  endtask

  function automatic logic [7:0] pick_punct();
    case ($urandom_range(0, 6))
      0:       return plt_pkg::CH_COMMA;
      1:       return plt_pkg::CH_COLON;
      2:       return plt_pkg::CH_SEMI;
      3:       return plt_pkg::CH_LPAREN;
      4:       return plt_pkg::CH_RPAREN;
      5:       return plt_pkg::CH_LBRACE;
      default: return plt_pkg::CH_RBRACE;
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0:       return plt_pkg::CH_SPACE;
      1:       return plt_pkg::CH_TAB;
      2:       return plt_pkg::CH_CR;
      default: return plt_pkg::CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (ends_word(c));
    return c;
  endfunction

  initial begin
    logic [7:0] q;
    logic [7:0] c;
    // directed: byte extremes, every punctuation, blanks, quoting corners
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(plt_pkg::CH_COMMA, 1'b0);
    add_byte(plt_pkg::CH_COLON, 1'b0);
    add_byte(plt_pkg::CH_SEMI, 1'b0);
    add_byte(plt_pkg::CH_LPAREN, 1'b0);
    add_byte(plt_pkg::CH_RPAREN, 1'b0);
    add_byte(plt_pkg::CH_LBRACE, 1'b0);
    add_byte(plt_pkg::CH_RBRACE, 1'b0);
    add_byte(plt_pkg::CH_SPACE, 1'b0);
    add_byte(plt_pkg::CH_TAB, 1'b0);
    add_byte(plt_pkg::CH_CR, 1'b0);
    add_byte(plt_pkg::CH_LF, 1'b0);
    add_byte(8'h61, 1'b0);
    add_byte(plt_pkg::CH_DQUOTE, 1'b0);     // quote ends a bare word, opens quoted
    add_byte(plt_pkg::CH_SQUOTE, 1'b0);     // other quote kind is plain text
    add_byte(plt_pkg::CH_BSLASH, 1'b0);
    add_byte(plt_pkg::CH_DQUOTE, 1'b0);     // escaped quote
    add_byte(plt_pkg::CH_DQUOTE, 1'b0);
    add_byte(plt_pkg::CH_SQUOTE, 1'b1);     // lone quote as last byte
    add_byte(8'h78, 1'b0);
    add_byte(plt_pkg::CH_BSLASH, 1'b0);     // backslash in a bare word
    add_byte(plt_pkg::CH_SQUOTE, 1'b1);     // ends word and closes empty quoted string
    add_byte(8'h7A, 1'b1);
    add_byte(plt_pkg::CH_DQUOTE, 1'b0);
    add_byte(plt_pkg::CH_BSLASH, 1'b1);     // text ends right after a backslash

    while (pending_bytes.size() < TARGET_BYTES) begin
      if ($urandom_range(0, 4) != 0) begin
        repeat ($urandom_range(1, 10)) begin
          case ($urandom_range(0, 4))
            0: add_byte(pick_punct(), 1'b0);
            1: repeat ($urandom_range(1, 3)) add_byte(pick_blank(), 1'b0);
            2: repeat ($urandom_range(1, 6)) add_byte(word_char(), 1'b0);
            default: begin
              q = $urandom_range(0, 1) ? plt_pkg::CH_SQUOTE : plt_pkg::CH_DQUOTE;
              add_byte(q, 1'b0);
              repeat ($urandom_range(0, 6)) begin
                case ($urandom_range(0, 7))
                  0: begin
                    add_byte(plt_pkg::CH_BSLASH, 1'b0);
                    add_byte(8'($urandom_range(0, 255)), 1'b0);
                  end
                  1: add_byte((q == plt_pkg::CH_SQUOTE) ? plt_pkg::CH_DQUOTE
                                                          : plt_pkg::CH_SQUOTE, 1'b0);
                  default: begin
                    do c = 8'($urandom_range(0, 255));
                    while (c == q || c == plt_pkg::CH_BSLASH);
                    add_byte(c, 1'b0);
                  end
                endcase
              end
              if ($urandom_range(0, 7) != 0) add_byte(q, 1'b0);
            end
          endcase
        end
      end else begin
        repeat ($urandom_range(1, 20))
          add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end
      close_text();
    end
    total_items = pending_bytes.size();
  end

  initial begin
    in_bus.valid      = 1'b0;
    in_bus.text_byte  = 8'd0;
    in_bus.final_byte = 1'b0;
    out_bus.ready     = 1'b0;
  end

  function automatic bit may_idle();
    return (bytes_taken < total_items - 200) && ((bytes_taken / 150) % 3 != 2);
  endfunction

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      send_gap     <= 0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (send_gap > 0) begin
        send_gap     <= send_gap - 1;
        in_bus.valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        next_item          = pending_bytes.pop_front();
        in_bus.valid      <= 1'b1;
        in_bus.text_byte  <= next_item.text_byte;
        in_bus.final_byte <= next_item.final_byte;
        if (may_idle() && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 14);
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // long output hold-off so the result queue fills and input backs up
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && bytes_taken >= 400) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end
    end
  end

  // token receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      recv_gap      <= 0;
    end else if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap      <= recv_gap - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
      if (may_idle() && $urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 14);
    end
  end

  // monitor: predict on accepted bytes, check accepted tokens
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        predict_tokens(in_bus.text_byte, in_bus.final_byte);
        bytes_taken <= bytes_taken + 1;
      end
      if (out_bus.valid && out_bus.ready) begin
        seen.token_kind = out_bus.token_kind;
        seen.char_value = out_bus.char_value;
        seen.was_quoted = out_bus.was_quoted;
        seen.run_last   = out_bus.run_last;
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected token kind=%0d char=%02h quoted=%0b last=%0b",
                   $time, seen.token_kind, seen.char_value, seen.was_quoted, seen.run_last);
          error_count++;
        end else begin
          want = expected_tokens.pop_front();
          if (want !== seen) begin
            $display("%0t: token mismatch exp kind=%0d char=%02h quoted=%0b last=%0b",
                     $time, want.token_kind, want.char_value, want.was_quoted, want.run_last);
            $display("%0t:                got kind=%0d char=%02h quoted=%0b last=%0b",
                     $time, seen.token_kind, seen.char_value, seen.was_quoted, seen.run_last);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk); while (bytes_taken < total_items || expected_tokens.size() != 0);
    repeat (20) @(negedge clk);
    if (expected_tokens.size() != 0) begin
      $display("%0t: %0d expected tokens never arrived", $time, expected_tokens.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
